// ===== src/apg_pkg.sv =====
// ----------------------------------------------------------------------------
// Arpeggio pattern generator package
// Shared types and register codes for the arpeggio pattern generator.
// ----------------------------------------------------------------------------
package apg_pkg;

  localparam int unsigned KEY_W  = 7;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [2:0] {
    MODE_UP         = 3'd0,
    MODE_DOWN       = 3'd1,
    MODE_UPDOWN     = 3'd2,
    MODE_DOWNUP     = 3'd3,
    MODE_SIGMA_UP   = 3'd4,
    MODE_SIGMA_DOWN = 3'd5
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ARP_MODE      = 2'd0,
    REG_KEY_COUNT     = 2'd1,
    REG_REPEAT_BOTTOM = 2'd2,
    REG_REPEAT_TOP    = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    SEG_LEAD   = 4'b0001,
    SEG_MAIN   = 4'b0010,
    SEG_TRAIL  = 4'b0100,
    SEG_APPEND = 4'b1000
  } seg_t;

endpackage

// ===== src/arpeggio_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// Arpeggio pattern generator
// Emits one key index of a repeating arpeggio pattern per step transaction.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in       input      in_valid/in_stall  in_restart
//  out      output     out_valid/out_stall out_key_index, out_pattern_last,
//                                          out_bad_count
//  cfg      input      cfg_we             cfg_index, cfg_wdata
//
// One transaction per cycle unless stalled; each result is registered.
// The pattern position and the result register are the only pipeline state.
// A new transaction is taken whenever the result register is empty or drains.
// Reset is synchronous and active low and restores the register defaults.
// Any configuration write returns the pattern to its first element.
module arpeggio_pattern_generator
  import apg_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KEY_W-1:0]  out_key_index,
  output logic              out_pattern_last,
  output logic              out_bad_count,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  localparam logic [CNT_W:0] MAX_K = (CNT_W+1)'(MAX_KEYS);

  logic [2:0]       mode_r;
  logic [CNT_W-1:0] count_r;
  logic             rep_bot_r;
  logic             rep_top_r;

  seg_t             seg_r, seg_nxt;
  logic [CNT_W-1:0] inner_r, inner_nxt;
  logic [CNT_W-1:0] outer_r, outer_nxt;

  logic             out_valid_r;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             last_r, last_nxt;
  logic             bad_r, bad_nxt;

  logic             accept;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] k_m1;
  logic [CNT_W-1:0] k_m2;
  mode_t            mode;
  logic             downish;
  logic             sigma;
  logic             has_append;
  logic             lead_len;
  logic             trail_len;
  seg_t             cur_seg;
  logic [CNT_W-1:0] cur_j;
  logic [CNT_W-1:0] cur_i;
  logic [CNT_W-1:0] jn;
  logic [CNT_W-1:0] in1;
  logic [CNT_W-1:0] key;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign k    = ({1'b0, count_r} > MAX_K) ? MAX_K[CNT_W-1:0] : count_r;
  assign k_m1 = k - CNT_W'(1);
  assign k_m2 = k - CNT_W'(2);

  always_comb begin
    case (mode_r)
      MODE_DOWN:       mode = MODE_DOWN;
      MODE_UPDOWN:     mode = MODE_UPDOWN;
      MODE_DOWNUP:     mode = MODE_DOWNUP;
      MODE_SIGMA_UP:   mode = MODE_SIGMA_UP;
      MODE_SIGMA_DOWN: mode = MODE_SIGMA_DOWN;
      default:         mode = MODE_UP;
    endcase
  end

  assign downish    = (mode == MODE_DOWN) || (mode == MODE_DOWNUP);
  assign sigma      = (mode == MODE_SIGMA_UP) || (mode == MODE_SIGMA_DOWN);
  assign has_append = ((mode == MODE_UPDOWN) || (mode == MODE_DOWNUP)) && (k_m2 != '0);
  assign lead_len   = downish ? rep_top_r : rep_bot_r;
  assign trail_len  = downish ? rep_bot_r : rep_top_r;

  always_comb begin
    cur_seg   = in_restart ? SEG_LEAD : seg_r;
    cur_j     = in_restart ? '0 : inner_r;
    cur_i     = in_restart ? '0 : outer_r;
    if (!sigma && cur_seg == SEG_LEAD && !lead_len) begin
      cur_seg = SEG_MAIN;
    end
    jn        = cur_j + CNT_W'(1);
    in1       = cur_i + CNT_W'(1);
    key       = '0;
    seg_nxt   = cur_seg;
    inner_nxt = jn;
    outer_nxt = cur_i;
    last_nxt  = 1'b0;

    if (sigma) begin
      key = (mode == MODE_SIGMA_UP) ? cur_j : k_m1 - cur_j;
      if (cur_j == cur_i) begin
        inner_nxt = '0;
        outer_nxt = in1;
        last_nxt  = (in1 >= k);
      end
    end else begin
      case (cur_seg)
        SEG_LEAD: begin
          key       = downish ? k_m1 : '0;
          seg_nxt   = SEG_MAIN;
          inner_nxt = '0;
        end
        SEG_MAIN: begin
          key = downish ? k_m1 - cur_j : cur_j;
          if (jn >= k) begin
            inner_nxt = '0;
            if (trail_len) begin
              seg_nxt = SEG_TRAIL;
            end else if (has_append) begin
              seg_nxt = SEG_APPEND;
            end else begin
              last_nxt = 1'b1;
            end
          end
        end
        SEG_TRAIL: begin
          key       = downish ? '0 : k_m1;
          inner_nxt = '0;
          if (has_append) begin
            seg_nxt = SEG_APPEND;
          end else begin
            last_nxt = 1'b1;
          end
        end
        SEG_APPEND: begin
          key = (mode == MODE_UPDOWN) ? k_m2 - cur_j : jn;
          if (jn >= k_m2) begin
            last_nxt = 1'b1;
          end
        end
        default: begin
          key      = '0;
          last_nxt = 1'b1;
        end
      endcase
    end

    if (last_nxt) begin
      seg_nxt   = SEG_LEAD;
      inner_nxt = '0;
      outer_nxt = '0;
    end

    key_nxt = key[KEY_W-1:0];
    bad_nxt = 1'b0;
    if (k < CNT_W'(2)) begin
      key_nxt   = '0;
      last_nxt  = 1'b0;
      bad_nxt   = 1'b1;
      seg_nxt   = SEG_LEAD;
      inner_nxt = '0;
      outer_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_UP;
      count_r   <= CNT_W'(2);
      rep_bot_r <= 1'b0;
      rep_top_r <= 1'b0;
      seg_r     <= SEG_LEAD;
      inner_r   <= '0;
      outer_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARP_MODE:      mode_r    <= cfg_wdata[2:0];
        REG_KEY_COUNT:     count_r   <= cfg_wdata[CNT_W-1:0];
        REG_REPEAT_BOTTOM: rep_bot_r <= cfg_wdata[0];
        REG_REPEAT_TOP:    rep_top_r <= cfg_wdata[0];
        default:           mode_r    <= mode_r;
      endcase
      seg_r   <= SEG_LEAD;
      inner_r <= '0;
      outer_r <= '0;
    end else if (accept) begin
      seg_r   <= seg_nxt;
      inner_r <= inner_nxt;
      outer_r <= outer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= key_nxt;
      last_r <= last_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_index    = key_r;
  assign out_pattern_last = last_r;
  assign out_bad_count    = bad_r;

endmodule

// ===== src/apg_checker.sv =====
// ----------------------------------------------------------------------------
// Arpeggio pattern generator checker
// Port-level properties of the arpeggio pattern generator, bound to the top.
// ----------------------------------------------------------------------------
module apg_checker
  import apg_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [KEY_W-1:0] out_key_index,
  input logic             out_pattern_last,
  input logic             out_bad_count
);

  // An empty result register never holds back the input side.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while no result is pending");

  // Every accepted transaction produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // An error result carries a zero key and never ends a pattern.
  a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_count) |-> (out_key_index == '0 && !out_pattern_last))
    else $error("error result with nonzero key or last flag");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_key_index) && $stable(out_pattern_last) &&
       $stable(out_bad_count)))
    else $error("stalled result changed");

endmodule

bind arpeggio_pattern_generator apg_checker u_apg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_key_index    (out_key_index),
  .out_pattern_last (out_pattern_last),
  .out_bad_count    (out_bad_count)
);

// ===== sim/tb_arpeggio_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// Arpeggio pattern generator testbench
// Drives step transactions with random restarts through many register
// settings, predicts every key index, last flag and count error in a local
// pattern model, and checks each result in order under random stalls.
// ----------------------------------------------------------------------------
module tb_arpeggio_pattern_generator;
  import apg_pkg::*;

  localparam int unsigned MAX_KEYS    = 128;
  localparam int unsigned STEP_TARGET = 1600;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned MAX_REPORTS = 50;

  localparam int unsigned PART_LEAD   = 0;
  localparam int unsigned PART_MAIN   = 1;
  localparam int unsigned PART_TRAIL  = 2;
  localparam int unsigned PART_APPEND = 3;
  localparam int unsigned PART_END    = 4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             bad;
  } arp_result_t;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic              in_restart       = 1'b0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [KEY_W-1:0]  out_key_index;
  logic              out_pattern_last;
  logic              out_bad_count;
  logic              cfg_we           = 1'b0;
  logic [IDX_W-1:0]  cfg_index        = '0;
  logic [DATA_W-1:0] cfg_wdata        = '0;

  logic [2:0]        arp_mode_r    = 3'd0;
  logic [CNT_W-1:0]  key_count_r   = 8'd2;
  logic              rep_bottom_r  = 1'b0;
  logic              rep_top_r     = 1'b0;
  logic [1:0]        part_pos      = '0;
  logic [7:0]        run_pos       = '0;
  logic [7:0]        run_num       = '0;

  logic              restart_queue[$];
  arp_result_t       pending_keys[$];
  int unsigned       steps_queued   = 0;
  int unsigned       steps_accepted = 0;
  int unsigned       keys_seen      = 0;
  int unsigned       mismatches     = 0;
  int unsigned       idle_cycles    = 0;
  bit                step_taken     = 1'b0;
  int unsigned       tx_gap         = 0;
  int unsigned       tx_calm        = 0;
  int unsigned       rx_gap         = 0;
  int unsigned       rx_calm        = 0;
  int unsigned       hold_left      = 0;
  int unsigned       next_hold_at   = 200;

  arpeggio_pattern_generator #(
    .MAX_KEYS(MAX_KEYS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key_index   (out_key_index),
    .out_pattern_last(out_pattern_last),
    .out_bad_count   (out_bad_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned part_length(mode_t m, int unsigned k, int unsigned p);
    logic downish;
    downish = (m == MODE_DOWN) || (m == MODE_DOWNUP);
    case (p)
      PART_LEAD:  return downish ? rep_top_r : rep_bottom_r;
      PART_MAIN:  return k;
      PART_TRAIL: return downish ? rep_bottom_r : rep_top_r;
      default:    return (m == MODE_UPDOWN || m == MODE_DOWNUP) ? k - 2 : 0;
    endcase
  endfunction

  function automatic bit settle_pos(mode_t m, int unsigned k, inout int unsigned p,
                                    inout int unsigned j, inout int unsigned i);
    if (m == MODE_SIGMA_UP || m == MODE_SIGMA_DOWN) begin
      if (j > i) begin
        i++;
        j = 0;
      end
      return i < k;
    end
    while (p < PART_END && j >= part_length(m, k, p)) begin
      p++;
      j = 0;
    end
    return p < PART_END;
  endfunction

  function automatic int unsigned key_at(mode_t m, int unsigned k, int unsigned p,
                                         int unsigned j);
    logic downish;
    downish = (m == MODE_DOWN) || (m == MODE_DOWNUP);
    if (m == MODE_SIGMA_UP) return j;
    if (m == MODE_SIGMA_DOWN) return k - 1 - j;
    case (p)
      PART_LEAD:  return downish ? k - 1 : 0;
      PART_MAIN:  return downish ? k - 1 - j : j;
      PART_TRAIL: return downish ? 0 : k - 1;
      default:    return (m == MODE_UPDOWN) ? k - 2 - j : 1 + j;
    endcase
  endfunction

  function automatic arp_result_t step_pattern(logic restart);
    int unsigned k;
    mode_t       m;
    int unsigned p;
    int unsigned j;
    int unsigned i;
    arp_result_t r;
    k = (key_count_r > MAX_KEYS) ? MAX_KEYS : key_count_r;
    m = (arp_mode_r > 3'd5) ? MODE_UP : mode_t'(arp_mode_r);
    if (restart || k < 2) begin
      part_pos = '0;
      run_pos  = '0;
      run_num  = '0;
    end
    if (k < 2) begin
      r.key  = '0;
      r.last = 1'b0;
      r.bad  = 1'b1;
      return r;
    end
    p = part_pos;
    j = run_pos;
    i = run_num;
    if (!settle_pos(m, k, p, j, i)) begin
      p = 0;
      j = 0;
      i = 0;
      void'(settle_pos(m, k, p, j, i));
    end
    r.key = KEY_W'(key_at(m, k, p, j));
    r.bad = 1'b0;
    j++;
    r.last = !settle_pos(m, k, p, j, i);
    if (r.last) begin
      p = 0;
      j = 0;
      i = 0;
    end
    part_pos = 2'(p);
    run_pos  = 8'(j);
    run_num  = 8'(i);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    if (mismatches < MAX_REPORTS) begin
      $display("Mismatch on %s at result %0d: got %0d, expected %0d",
               field, keys_seen, got, want);
    end
    mismatches++;
  endtask

  task automatic push_step(logic restart);
    restart_queue = {restart_queue, restart};
    steps_queued++;
  endtask

  task automatic queue_steps(int unsigned count, int unsigned restart_pct);
    repeat (count) push_step($urandom_range(0, 99) < restart_pct);
  endtask

  task automatic wait_idle();
    while (steps_accepted != steps_queued || pending_keys.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_ARP_MODE:      arp_mode_r   = data[2:0];
      REG_KEY_COUNT:     key_count_r  = data;
      REG_REPEAT_BOTTOM: rep_bottom_r = data[0];
      REG_REPEAT_TOP:    rep_top_r    = data[0];
      default:           ;
    endcase
    part_pos = '0;
    run_pos  = '0;
    run_num  = '0;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin
    arp_result_t want;
    step_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_keys.size() == 0) begin
          report_mismatch("key_index with nothing expected", out_key_index, 0);
        end else begin
          want = pending_keys.pop_front();
          if (out_key_index !== want.key)
            report_mismatch("key_index", out_key_index, want.key);
          if (out_pattern_last !== want.last)
            report_mismatch("pattern_last", out_pattern_last, want.last);
          if (out_bad_count !== want.bad)
            report_mismatch("bad_count", out_bad_count, want.bad);
        end
        keys_seen++;
      end
      if (in_valid && !in_stall) begin
        step_taken = 1'b1;
        pending_keys = {pending_keys, step_pattern(in_restart)};
        steps_accepted++;
      end
      if (step_taken || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !step_taken) begin
      in_valid <= 1'b1;
    end else if (tx_gap != 0) begin
      in_valid <= 1'b0;
      tx_gap   <= tx_gap - 1;
    end else if (restart_queue.size() != 0) begin
      in_valid   <= 1'b1;
      in_restart <= restart_queue.pop_front();
      if (tx_calm != 0) begin
        tx_calm <= tx_calm - 1;
        tx_gap  <= 0;
      end else begin
        tx_gap <= pick_gap();
        if ($urandom_range(0, 39) == 0) tx_calm <= $urandom_range(20, 80);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (keys_seen >= next_hold_at && restart_queue.size() >= 8) begin
      out_stall    <= 1'b1;
      hold_left    <= LONG_HOLD;
      next_hold_at <= keys_seen + 400;
    end else if (rx_calm != 0) begin
      out_stall <= 1'b0;
      rx_calm   <= rx_calm - 1;
    end else if (rx_gap != 0) begin
      out_stall <= 1'b1;
      rx_gap    <= rx_gap - 1;
    end else begin
      out_stall <= 1'b0;
      rx_gap    <= pick_gap();
      if ($urandom_range(0, 39) == 0) rx_calm <= $urandom_range(30, 120);
    end
  end

  initial begin
    int unsigned pick;
    bit          wrote;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    push_step(1'b0);
    push_step(1'b0);
    push_step(1'b1);
    push_step(1'b0);
    write_reg(REG_KEY_COUNT, 8'd0);
    push_step(1'b0);
    push_step(1'b1);
    write_reg(REG_KEY_COUNT, 8'd1);
    push_step(1'b0);
    write_reg(REG_KEY_COUNT, 8'hFF);
    write_reg(REG_ARP_MODE, 8'd5);
    queue_steps(3, 0);
    write_reg(REG_ARP_MODE, 8'hFF);
    write_reg(REG_KEY_COUNT, 8'd3);
    write_reg(REG_REPEAT_BOTTOM, 8'hFF);
    write_reg(REG_REPEAT_TOP, 8'd1);
    queue_steps(6, 0);
    write_reg(REG_ARP_MODE, 8'd2);
    write_reg(REG_KEY_COUNT, 8'd4);
    push_step(1'b0);
    push_step(1'b0);
    push_step(1'b1);
    queue_steps(3, 0);

    write_reg(REG_ARP_MODE, 8'd0);
    write_reg(REG_KEY_COUNT, 8'd128);
    queue_steps(135, 1);
    write_reg(REG_ARP_MODE, 8'd3);
    write_reg(REG_REPEAT_BOTTOM, 8'd0);
    write_reg(REG_REPEAT_TOP, 8'hFE);
    queue_steps(260, 0);

    while (steps_queued < STEP_TARGET) begin
      wrote = 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_ARP_MODE, DATA_W'($urandom));
        wrote = 1'b1;
      end
      if ($urandom_range(0, 1) == 1 || !wrote) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      write_reg(REG_KEY_COUNT, DATA_W'($urandom_range(0, 1)));
        else if (pick == 1) write_reg(REG_KEY_COUNT, DATA_W'($urandom_range(128, 255)));
        else if (pick == 2) write_reg(REG_KEY_COUNT, DATA_W'($urandom_range(100, 128)));
        else                write_reg(REG_KEY_COUNT, DATA_W'($urandom_range(2, 9)));
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_REPEAT_BOTTOM, DATA_W'($urandom));
      if ($urandom_range(0, 2) == 0) write_reg(REG_REPEAT_TOP, DATA_W'($urandom));
      queue_steps($urandom_range(8, 48), ($urandom_range(0, 5) == 0) ? 40 : 3);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
